>>> sv/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an event implies a condition in the previous cycle.
`define ASSERT_CAUSE(label, trig, cause, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (trig) |-> $past(cause)) else $error(msg);

`endif

>>> sv/rgbf_pkg.sv
package rgbf_pkg;

  localparam int LVL_W = 8;
  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] FADE_DIVIDE = 6'd50;
  localparam logic [LVL_W-1:0] LVL_MAX     = 8'd255;
  localparam logic [LVL_W-1:0] LVL_MIN     = 8'd0;
  localparam logic [LVL_W-1:0] LVL_HALF    = 8'd128;

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_RED    = 3'd1,
    FUNC_GREEN  = 3'd2,
    FUNC_BLUE   = 3'd3,
    FUNC_TOGGLE = 3'd4
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [LVL_W-1:0] level;
  } in_t;

  typedef struct packed {
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
    logic             fade_active;
  } out_t;

  typedef struct packed {
    out_t             lvl;
    logic [CNT_W-1:0] cnt;
  } stat_t;

endpackage

>>> sv/rgbf_chan.sv
module rgbf_chan (
  input  logic [rgbf_pkg::LVL_W-1:0] now,
  input  logic [rgbf_pkg::LVL_W-1:0] goal,
  input  logic                       fade_on,
  input  logic [rgbf_pkg::CNT_W-1:0] cnt_in,
  output logic [rgbf_pkg::LVL_W-1:0] now_nxt,
  output logic [rgbf_pkg::LVL_W-1:0] goal_nxt,
  output logic [rgbf_pkg::CNT_W-1:0] cnt_out
);

  logic [rgbf_pkg::CNT_W:0] cnt_inc;
  logic                     step;

  always_comb begin
    cnt_inc  = {1'b0, cnt_in} + {{rgbf_pkg::CNT_W{1'b0}}, 1'b1};
    cnt_out  = cnt_in;
    step     = 1'b1;
    now_nxt  = now;
    goal_nxt = goal;
    if (fade_on) begin
      // advance the shared divider; step only when it wraps
      if (cnt_inc >= {1'b0, rgbf_pkg::FADE_DIVIDE}) begin
        cnt_out = '0;
      end else begin
        cnt_out = cnt_inc[rgbf_pkg::CNT_W-1:0];
      end
      step = (cnt_out == '0);
    end
    if (step) begin
      if (now < goal) begin
        now_nxt = now + 8'd1;
      end else if (now > goal) begin
        now_nxt = now - 8'd1;
      end else if (fade_on) begin
        // bounce between fully on and fully off
        if (goal == rgbf_pkg::LVL_MIN) begin
          goal_nxt = rgbf_pkg::LVL_MAX;
        end else if (goal == rgbf_pkg::LVL_MAX) begin
          goal_nxt = rgbf_pkg::LVL_MIN;
        end
      end
    end
  end

endmodule

>>> sv/rgbf_core.sv
module rgbf_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  rgbf_pkg::in_t   item,
  output rgbf_pkg::out_t  res,
  output rgbf_pkg::stat_t stat
);

  logic [rgbf_pkg::LVL_W-1:0] red_now_r, red_goal_r, green_now_r, green_goal_r;
  logic [rgbf_pkg::LVL_W-1:0] blue_now_r, blue_goal_r;
  logic                       fade_on_r;
  logic [rgbf_pkg::CNT_W-1:0] cnt_r;

  logic [rgbf_pkg::LVL_W-1:0] red_now_nxt, red_goal_nxt, green_now_nxt, green_goal_nxt;
  logic [rgbf_pkg::LVL_W-1:0] blue_now_nxt, blue_goal_nxt;
  logic                       fade_on_nxt;
  logic [rgbf_pkg::CNT_W-1:0] cnt_nxt;

  logic [rgbf_pkg::LVL_W-1:0] r_now_t, r_goal_t, g_now_t, g_goal_t, b_now_t, b_goal_t;
  logic [rgbf_pkg::CNT_W-1:0] cnt_rg, cnt_gb, cnt_b;
  logic [rgbf_pkg::LVL_W-1:0] goal_cmd;

  // visit order on a tick: red, green, blue
  rgbf_chan u_red (
    .now(red_now_r), .goal(red_goal_r), .fade_on(fade_on_r), .cnt_in(cnt_r),
    .now_nxt(r_now_t), .goal_nxt(r_goal_t), .cnt_out(cnt_rg)
  );

  rgbf_chan u_green (
    .now(green_now_r), .goal(green_goal_r), .fade_on(fade_on_r), .cnt_in(cnt_rg),
    .now_nxt(g_now_t), .goal_nxt(g_goal_t), .cnt_out(cnt_gb)
  );

  rgbf_chan u_blue (
    .now(blue_now_r), .goal(blue_goal_r), .fade_on(fade_on_r), .cnt_in(cnt_gb),
    .now_nxt(b_now_t), .goal_nxt(b_goal_t), .cnt_out(cnt_b)
  );

  always_comb begin
    goal_cmd       = rgbf_pkg::LVL_MAX - item.level;
    red_now_nxt    = red_now_r;
    red_goal_nxt   = red_goal_r;
    green_now_nxt  = green_now_r;
    green_goal_nxt = green_goal_r;
    blue_now_nxt   = blue_now_r;
    blue_goal_nxt  = blue_goal_r;
    fade_on_nxt    = fade_on_r;
    cnt_nxt        = cnt_r;
    if (fire) begin
      case (item.func)
        rgbf_pkg::FUNC_TICK: begin
          red_now_nxt    = r_now_t;
          red_goal_nxt   = r_goal_t;
          green_now_nxt  = g_now_t;
          green_goal_nxt = g_goal_t;
          blue_now_nxt   = b_now_t;
          blue_goal_nxt  = b_goal_t;
          cnt_nxt        = cnt_b;
        end
        rgbf_pkg::FUNC_RED:   red_goal_nxt   = goal_cmd;
        rgbf_pkg::FUNC_GREEN: green_goal_nxt = goal_cmd;
        rgbf_pkg::FUNC_BLUE:  blue_goal_nxt  = goal_cmd;
        rgbf_pkg::FUNC_TOGGLE: begin
          if (!fade_on_r) begin
            red_now_nxt    = rgbf_pkg::LVL_MIN;
            red_goal_nxt   = rgbf_pkg::LVL_MAX;
            green_now_nxt  = rgbf_pkg::LVL_MAX;
            green_goal_nxt = rgbf_pkg::LVL_MIN;
            blue_now_nxt   = rgbf_pkg::LVL_HALF;
            blue_goal_nxt  = rgbf_pkg::LVL_MIN;
          end
          fade_on_nxt = !fade_on_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_now_r    <= rgbf_pkg::LVL_MAX;
      red_goal_r   <= rgbf_pkg::LVL_MIN;
      green_now_r  <= rgbf_pkg::LVL_MAX;
      green_goal_r <= rgbf_pkg::LVL_MIN;
      blue_now_r   <= rgbf_pkg::LVL_MAX;
      blue_goal_r  <= rgbf_pkg::LVL_MIN;
      fade_on_r    <= 1'b0;
      cnt_r        <= '0;
    end else begin
      red_now_r    <= red_now_nxt;
      red_goal_r   <= red_goal_nxt;
      green_now_r  <= green_now_nxt;
      green_goal_r <= green_goal_nxt;
      blue_now_r   <= blue_now_nxt;
      blue_goal_r  <= blue_goal_nxt;
      fade_on_r    <= fade_on_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_comb begin
    res.red_level   = red_now_nxt;
    res.green_level = green_now_nxt;
    res.blue_level  = blue_now_nxt;
    res.fade_active = fade_on_nxt;
    stat.lvl.red_level   = red_now_r;
    stat.lvl.green_level = green_now_r;
    stat.lvl.blue_level  = blue_now_r;
    stat.lvl.fade_active = fade_on_r;
    stat.cnt             = cnt_r;
  end

endmodule

>>> sv/rgb_led_fade_ramp_controller.sv
// RGB LED fade ramp controller. Takes one command per cycle unless stalled
// (tick, set a channel goal, toggle fade) and returns one result per
// command: the three current compare levels and the fade flag as they stand
// after the command. The command lands in an input register, then the
// channel state and the result register update together.
// Sustained rate is one command per clock; the only limit is the single
// state update per cycle, and the input is held off only while a result
// waits under out_stall with the next command already registered.
`include "assert_macros.svh"

module rgb_led_fade_ramp_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rgbf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rgbf_pkg::out_t out_data
);

  logic            in_vld_r;
  rgbf_pkg::in_t   in_r;
  logic            out_vld_r;
  rgbf_pkg::out_t  out_r;
  logic            adv;
  logic            fire;
  logic            toggle_fire;
  rgbf_pkg::out_t  res;
  rgbf_pkg::stat_t stat;

  assign adv         = !out_vld_r || !out_stall;
  assign fire        = in_vld_r && adv;
  assign in_stall    = in_vld_r && !adv;
  assign toggle_fire = fire && (in_r.func == rgbf_pkg::FUNC_TOGGLE);

  rgbf_core u_core (
    .clk(clk), .rst_n(rst_n), .fire(fire), .item(in_r), .res(res), .stat(stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // hold payloads while stalled
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_stall_cause, !in_stall || (out_valid && out_stall), "stall without backpressure")
  `ASSERT_CLK(a_cnt_range, stat.cnt < rgbf_pkg::FADE_DIVIDE, "fade divider out of range")
  `ASSERT_CAUSE(a_fade_on, $rose(stat.lvl.fade_active), toggle_fire, "fade on without toggle")

endmodule
